/* src/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg: point-in-polygon crossing test types
// Transfer payloads for the vertex and result channels, plus the fixed width
// of the coordinate fields.
// ----------------------------------------------------------------------------
package pip_pkg;

  // width of every coordinate field on the vertex channel
  localparam int FieldBits = 32;

  // one polygon vertex, with the test point riding along
  typedef struct packed {
    logic signed [FieldBits-1:0] vertex_x;
    logic signed [FieldBits-1:0] vertex_y;
    logic signed [FieldBits-1:0] test_x;
    logic signed [FieldBits-1:0] test_y;
    logic                        first_vertex;
    logic                        last_vertex;
  } vertex_t;

  // one polygon verdict
  typedef struct packed {
    logic inside_res;
    logic on_vertex;
  } result_t;

endpackage

/* src/point_in_polygon_crossing_test.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test: streamed ray-casting point-in-polygon test
// Vertices arrive one per transfer. Each edge (and the closing edge on the
// last vertex) is tested against a horizontal ray from the test point to the
// largest coordinate value; crossing parity and an exact-vertex-hit flag
// decide the verdict.
//
//   channel  dir  handshake                     payload
//   vertex   in   vertex_valid / vertex_stall   pip_pkg::vertex_t
//   result   out  result_valid / result_stall   pip_pkg::result_t
//
// One vertex per cycle sustained unless a stalled result backs up. A last
// vertex's result passes the input register, loaded at the transfer, then
// the partial-product, product and result registers (the exact wide cross
// products set this depth). Non-last vertices make no result. Reset clears
// the polygon state and all stage valid bits. A stalled result holds while
// the pipeline keeps taking vertices; the input stalls once the next last
// vertex is held at the product register and the two stages behind it fill.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test #(
  parameter int COORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vertex_valid,
  output logic             vertex_stall,
  input  pip_pkg::vertex_t vertex,
  output logic             result_valid,
  input  logic             result_stall,
  output pip_pkg::result_t result
);
  import pip_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int InBits = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam int DW     = CW + 1;          // coordinate difference width
  localparam int PW     = 2 * DW;          // exact product width
  localparam int H      = (DW + 1) / 2;    // low half of a split operand
  localparam int HW     = DW - H;          // high half of a split operand

  typedef logic signed [CW-1:0] coord_t;

  // four partial products of one split multiplication
  typedef struct packed {
    logic signed [2*HW-1:0] hh;
    logic signed [HW+H:0]   hl;
    logic signed [HW+H:0]   lh;
    logic [2*H-1:0]         ll;
  } part_t;

  typedef struct packed {
    logic first;
    logic last;
    logic hit;
  } flag_t;

  typedef struct packed {
    flag_t      f;
    logic [1:0] straddle;   // per edge: endpoints on opposite sides of the ray
  } ctl_t;

  // far right end of the ray
  localparam coord_t RayEnd = {1'b0, {(CW-1){1'b1}}};

  // low InBits of a field, sign-extended to the coordinate width
  function automatic coord_t to_coord(input logic [FieldBits-1:0] f);
    logic signed [InBits-1:0] t;
    t = f[InBits-1:0];
    return CW'(t);
  endfunction

  // signed multiply as four half-width partial products
  function automatic part_t split_mul(input logic signed [DW-1:0] a,
                                      input logic signed [DW-1:0] b);
    part_t                p;
    logic signed [HW-1:0] ah;
    logic signed [HW-1:0] bh;
    logic signed [H:0]    al;
    logic signed [H:0]    bl;
    ah   = a[DW-1:H];
    bh   = b[DW-1:H];
    al   = {1'b0, a[H-1:0]};
    bl   = {1'b0, b[H-1:0]};
    p.hh = ah * bh;
    p.hl = ah * bl;
    p.lh = al * bh;
    p.ll = a[H-1:0] * b[H-1:0];
    return p;
  endfunction

  // recombine the partial products into the exact product
  function automatic logic signed [PW-1:0] join_mul(input part_t p);
    logic signed [PW-1:0] hh;
    logic signed [PW-1:0] hl;
    logic signed [PW-1:0] lh;
    logic signed [PW-1:0] ll;
    hh = PW'($signed(p.hh));
    hl = PW'($signed(p.hl));
    lh = PW'($signed(p.lh));
    ll = PW'(p.ll);
    return (hh <<< (2 * H)) + ((hl + lh) <<< H) + ll;
  endfunction

  // polygon state
  coord_t point_x, point_y, start_x, start_y, prev_x, prev_y;
  coord_t point_x_next, point_y_next, start_x_next, start_y_next;
  coord_t v_x, v_y;
  logic   crossing_parity, vertex_hit;

  // stage 1: edge endpoints, edge 0 = previous->current, edge 1 = closing
  logic   s1_valid;
  coord_t s1_ax [2];
  coord_t s1_ay [2];
  coord_t s1_bx [2];
  coord_t s1_by [2];
  coord_t s1_px, s1_py;
  flag_t  s1_flags;

  // stage 2: partial products
  logic  s2_valid;
  part_t s2_l  [2];
  part_t s2_r1 [2];
  part_t s2_r2 [2];
  ctl_t  s2_ctl;

  // stage 3: full products
  logic                 s3_valid;
  logic signed [PW-1:0] s3_l  [2];
  logic signed [PW-1:0] s3_r1 [2];
  logic signed [PW-1:0] s3_r2 [2];
  ctl_t                 s3_ctl;

  // combinational per-stage results
  part_t                part_l  [2];
  part_t                part_r1 [2];
  part_t                part_r2 [2];
  logic [1:0]           straddle;
  logic signed [PW-1:0] prod_l  [2];
  logic signed [PW-1:0] prod_r1 [2];
  logic signed [PW-1:0] prod_r2 [2];
  logic [1:0]           crossing;
  logic                 ray_open;
  logic                 par_next, hit_next;

  // flow control
  logic take, out_free, s3_fire, s3_open, s2_open, s1_open;

  assign out_free     = !result_valid || !result_stall;
  assign s3_fire      = s3_valid && (!s3_ctl.f.last || out_free);
  assign s3_open      = !s3_valid || s3_fire;
  assign s2_open      = !s2_valid || s3_open;
  assign s1_open      = !s1_valid || s2_open;
  assign vertex_stall = !s1_open;
  assign take         = vertex_valid && s1_open;

  // input decode and state for the incoming vertex
  assign v_x          = to_coord(vertex.vertex_x);
  assign v_y          = to_coord(vertex.vertex_y);
  assign point_x_next = vertex.first_vertex ? to_coord(vertex.test_x) : point_x;
  assign point_y_next = vertex.first_vertex ? to_coord(vertex.test_y) : point_y;
  assign start_x_next = vertex.first_vertex ? v_x : start_x;
  assign start_y_next = vertex.first_vertex ? v_y : start_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x  <= '0;
      point_y  <= '0;
      start_x  <= '0;
      start_y  <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_open) s1_valid <= vertex_valid;
      if (take) begin
        point_x  <= point_x_next;
        point_y  <= point_y_next;
        start_x  <= start_x_next;
        start_y  <= start_y_next;
        prev_x   <= v_x;
        prev_y   <= v_y;
        s1_ax[0] <= prev_x;
        s1_ay[0] <= prev_y;
        s1_bx[0] <= v_x;
        s1_by[0] <= v_y;
        s1_ax[1] <= v_x;
        s1_ay[1] <= v_y;
        s1_bx[1] <= start_x_next;
        s1_by[1] <= start_y_next;
        s1_px    <= point_x_next;
        s1_py    <= point_y_next;
        s1_flags <= '{first: vertex.first_vertex, last: vertex.last_vertex,
                      hit: (v_x == point_x_next) && (v_y == point_y_next)};
      end
    end
  end

  // stage 1: differences, ray-side test, split multiplies
  // The ray side tests need no product: the ray is horizontal and its end is
  // never left of the test point.
  assign ray_open = (s1_px != RayEnd);

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      part_l[e]   = split_mul(DW'(s1_bx[e]) - DW'(s1_ax[e]), DW'(s1_py) - DW'(s1_ay[e]));
      part_r1[e]  = split_mul(DW'(s1_by[e]) - DW'(s1_ay[e]), DW'(s1_px) - DW'(s1_ax[e]));
      part_r2[e]  = split_mul(DW'(s1_by[e]) - DW'(s1_ay[e]), DW'(RayEnd) - DW'(s1_ax[e]));
      straddle[e] = ray_open && ((s1_ay[e] > s1_py) != (s1_by[e] > s1_py));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      if (s2_open) s2_valid <= s1_valid;
      if (s2_open && s1_valid) begin
        s2_l     <= part_l;
        s2_r1    <= part_r1;
        s2_r2    <= part_r2;
        s2_ctl   <= '{f: s1_flags, straddle: straddle};
      end
    end
  end

  // stage 2: recombine partial products
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      prod_l[e]  = join_mul(s2_l[e]);
      prod_r1[e] = join_mul(s2_r1[e]);
      prod_r2[e] = join_mul(s2_r2[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      if (s3_open) s3_valid <= s2_valid;
      if (s3_open && s2_valid) begin
        s3_l   <= prod_l;
        s3_r1  <= prod_r1;
        s3_r2  <= prod_r2;
        s3_ctl <= s2_ctl;
      end
    end
  end

  // stage 3: orientation compares, parity and hit update
  // Edge crosses when it straddles the ray and the test point and the ray end lie on opposite sides.
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      crossing[e] = s3_ctl.straddle[e] &&
                    ((s3_l[e] > s3_r1[e]) != (s3_l[e] > s3_r2[e]));
    end
  end

  assign par_next = s3_ctl.f.first ? 1'b0 : (crossing_parity ^ crossing[0]);
  assign hit_next = s3_ctl.f.hit || (!s3_ctl.f.first && vertex_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      vertex_hit      <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (s3_fire) begin
        crossing_parity <= par_next;
        vertex_hit      <= hit_next;
      end
      result_valid <= (s3_fire && s3_ctl.f.last) || (result_valid && result_stall);
      if (s3_fire && s3_ctl.f.last) begin
        result <= '{inside_res: (par_next ^ crossing[1]) || hit_next,
                    on_vertex:  hit_next};
      end
    end
  end

  // checks
  a_vertex_means_inside: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.on_vertex || result.inside_res))
    else $error("on_vertex result without inside_res");

  a_no_result_from_inner_vertex: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_ctl.f.last && !(result_valid && result_stall)) |=> !result_valid)
    else $error("result produced by a vertex that is not last");

  a_empty_front_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !vertex_stall)
    else $error("vertex stalled with an empty input stage");

  a_first_restarts: assert property (@(posedge clk) disable iff (rst)
    (s3_fire && s3_ctl.f.first) |=>
      (!crossing_parity && (vertex_hit == $past(s3_ctl.f.hit))))
    else $error("first vertex did not restart the polygon state");

  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_fire) |=> s3_valid)
    else $error("stalled stage 3 item lost");

endmodule

/* bench/pip_verdict_checker.sv */
// ----------------------------------------------------------------------------
// pip_verdict_checker: verdict predictor and scoreboard for the crossing test
// Watches both channels of point_in_polygon_crossing_test. Every vertex
// transfer runs through its own copy of the ray-casting state. A last vertex
// queues the verdict it should produce. Every result transfer is compared
// against the oldest queued verdict.
// ----------------------------------------------------------------------------
module pip_verdict_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             vertex_valid,
  input  logic             vertex_stall,
  input  pip_pkg::vertex_t vertex,
  input  logic             result_valid,
  input  logic             result_stall,
  input  pip_pkg::result_t result,
  output int               mismatches,
  output int               verdicts_owed
);
  import pip_pkg::*;

  // wide enough for exact products of 33-bit coordinate differences
  typedef logic signed [67:0] wide_t;

  // far right end of the ray: largest 32-bit coordinate
  localparam wide_t RayEnd = 68'sd2147483647;

  // polygon state
  wide_t   point_x, point_y;
  wide_t   start_x, start_y;
  wide_t   prev_x, prev_y;
  logic    parity;
  logic    vertex_hit;
  result_t pending_verdicts[$];
  int      fail_total;

  // true when c lies strictly left of a->b; collinear counts as right
  function automatic logic left_of(input wide_t ax, ay, bx, by, cx, cy);
    return (bx - ax) * (cy - ay) > (by - ay) * (cx - ax);
  endfunction

  // does edge a->b cross the ray from the test point to the far right end
  function automatic logic crosses_ray(input wide_t ax, ay, bx, by);
    logic s1, s2, s3, s4;
    s1 = left_of(point_x, point_y, RayEnd, point_y, ax, ay);
    s2 = left_of(point_x, point_y, RayEnd, point_y, bx, by);
    s3 = left_of(ax, ay, bx, by, point_x, point_y);
    s4 = left_of(ax, ay, bx, by, RayEnd, point_y);
    return (s1 != s2) && (s3 != s4);
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    wide_t   vx, vy;
    logic    closing;
    if (rst) begin
      point_x    = '0;
      point_y    = '0;
      start_x    = '0;
      start_y    = '0;
      prev_x     = '0;
      prev_y     = '0;
      parity     = 1'b0;
      vertex_hit = 1'b0;
      fail_total = 0;
      pending_verdicts.delete();
    end else begin
      // result transfer: compare with the oldest verdict owed
      if (result_valid && !result_stall) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transfer with no verdict owed");
          fail_total++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0b, actual %0b", want.inside_res,
                   result.inside_res);
            fail_total++;
          end
          if (result.on_vertex !== want.on_vertex) begin
            $error("on_vertex: expected %0b, actual %0b", want.on_vertex,
                   result.on_vertex);
            fail_total++;
          end
        end
      end

      // vertex transfer: advance the polygon state
      if (vertex_valid && !vertex_stall) begin
        vx = $signed(vertex.vertex_x);
        vy = $signed(vertex.vertex_y);
        if (vertex.first_vertex) begin
          point_x    = $signed(vertex.test_x);
          point_y    = $signed(vertex.test_y);
          start_x    = vx;
          start_y    = vy;
          parity     = 1'b0;
          vertex_hit = (vx == point_x) && (vy == point_y);
        end else begin
          if (crosses_ray(prev_x, prev_y, vx, vy)) parity = !parity;
          if (vx == point_x && vy == point_y) vertex_hit = 1'b1;
        end
        prev_x = vx;
        prev_y = vy;
        // closing edge counts toward this verdict only
        if (vertex.last_vertex) begin
          closing         = parity ^ crosses_ray(vx, vy, start_x, start_y);
          want.inside_res = closing || vertex_hit;
          want.on_vertex  = vertex_hit;
          pending_verdicts.push_back(want);
        end
      end
    end
    mismatches    <= fail_total;
    verdicts_owed <= pending_verdicts.size();
  end

endmodule

/* bench/point_in_polygon_crossing_test_tb.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_tb: stimulus and verdict for the crossing test
// Sends directed polygons (corner coordinates, vertex hits, rays through
// vertices, unmarked and unterminated runs), then random polygons under
// several sender/receiver pacing phases, including a long receiver hold-off.
// Checking is done by pip_verdict_checker.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test_tb;
  import pip_pkg::*;

  localparam int Limit = 400000;
  localparam logic signed [31:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [31:0] CoordMax = 32'sh7FFF_FFFF;

  // how coordinates of a random polygon are spread
  typedef enum int {SpreadTight, SpreadMid, SpreadFull, SpreadExtreme} spread_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    vertex_valid = 1'b0;
  logic    vertex_stall;
  vertex_t vertex       = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int cycle_count   = 0;
  int mismatches;
  int verdicts_owed;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_in_polygon_crossing_test uut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  pip_verdict_checker verdict_check (
    .clk           (clk),
    .rst           (rst),
    .vertex_valid  (vertex_valid),
    .vertex_stall  (vertex_stall),
    .vertex        (vertex),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == Limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one vertex transfer, with random idle cycles ahead of it
  task automatic send_vertex(input logic signed [31:0] vx, vy, tx, ty,
                             input logic first, last);
    vertex_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    v.vertex_x     = vx;
    v.vertex_y     = vy;
    v.test_x       = tx;
    v.test_y       = ty;
    v.first_vertex = first;
    v.last_vertex  = last;
    vertex_valid <= 1'b1;
    vertex       <= v;
    do @(posedge clk); while (vertex_stall);
  endtask

  // stop sending until every owed verdict has come out
  task automatic drain();
    vertex_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord(input spread_t spread);
    case (spread)
      SpreadTight: return $urandom_range(128) - 64;
      SpreadMid:   return $signed($urandom) >>> 14;
      SpreadFull:  return $urandom;
      default: begin
        case ($urandom_range(5))
          0: return CoordMin;
          1: return CoordMax;
          2: return 0;
          3: return -1;
          4: return CoordMin + 1;
          default: return CoordMax - 1;
        endcase
      end
    endcase
  endfunction

  // one random polygon; the test point sometimes sits on a vertex or on the
  // horizontal line through one
  task automatic send_polygon(input int count, input spread_t spread,
                              input logic mark_first, mark_last);
    logic signed [31:0] px[], py[];
    logic signed [31:0] tx, ty;
    spread_t            sp;
    int                 hit_at;
    px = new[count];
    py = new[count];
    tx = pick_coord(spread);
    ty = pick_coord(spread);
    for (int i = 0; i < count; i++) begin
      sp    = ($urandom_range(7) == 0) ? SpreadExtreme : spread;
      px[i] = pick_coord(sp);
      py[i] = pick_coord(sp);
    end
    if ($urandom_range(3) == 0) py[$urandom_range(count - 1)] = ty;
    if ($urandom_range(4) == 0) begin
      hit_at     = $urandom_range(count - 1);
      px[hit_at] = tx;
      py[hit_at] = ty;
    end
    for (int i = 0; i < count; i++) begin
      send_vertex(px[i], py[i], (i == 0) ? tx : $urandom, (i == 0) ? ty : $urandom,
                  mark_first && i == 0, mark_last && i == count - 1);
    end
  endtask

  // random polygons, mostly well formed with some unmarked or open runs
  task automatic random_run(input int items);
    int sent;
    int count;
    int roll;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 5) count = $urandom_range(2, 1);
      else if (roll < 10) count = $urandom_range(20, 9);
      else count = $urandom_range(8, 3);
      roll = $urandom_range(99);
      send_polygon(count, spread_t'($urandom_range(3)), roll >= 5,
                   !(roll >= 5 && roll < 9));
      sent += count;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // vertices with no first mark continue from the cleared state
    send_vertex(5, -3, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(-7, 4, $urandom, $urandom, 1'b0, 1'b1);
    // single-vertex polygons at the corners, on and off the test point
    send_vertex(CoordMin, CoordMax, CoordMin, CoordMax, 1'b1, 1'b1);
    send_vertex(CoordMax, CoordMin, 0, 0, 1'b1, 1'b1);
    // square around the test point
    send_vertex(-10, -10, 0, 0, 1'b1, 1'b0);
    send_vertex(10, -10, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(10, 10, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(-10, 10, $urandom, $urandom, 1'b0, 1'b1);
    // triangle spanning the full coordinate range
    send_vertex(CoordMin, CoordMin, 0, 0, 1'b1, 1'b0);
    send_vertex(CoordMax, CoordMin, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(0, CoordMax, $urandom, $urandom, 1'b0, 1'b1);
    // test point equals a later vertex
    send_vertex(0, 0, 5, 5, 1'b1, 1'b0);
    send_vertex(5, 5, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(10, 0, $urandom, $urandom, 1'b0, 1'b1);
    // ray runs through vertices of a diamond
    send_vertex(5, 0, 0, 0, 1'b1, 1'b0);
    send_vertex(0, 5, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(-5, 0, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(0, -5, $urandom, $urandom, 1'b0, 1'b1);
    // test point at the far end of the ray
    send_vertex(CoordMax - 4, -3, CoordMax, 0, 1'b1, 1'b0);
    send_vertex(CoordMax, 3, $urandom, $urandom, 1'b0, 1'b0);
    send_vertex(CoordMax - 8, 3, $urandom, $urandom, 1'b0, 1'b1);
    // a last vertex leaves the state in place for the next unmarked one
    send_vertex(-20, 0, $urandom, $urandom, 1'b0, 1'b1);
    drain();

    // full rate both sides
    random_run(350);
    drain();

    // receiver holds off while the sender keeps pushing
    hold_cycles <= 300;
    random_run(60);
    drain();

    // sender idles
    send_idle_pct <= 64;
    random_run(400);
    drain();

    // receiver stalls
    send_idle_pct <= 0;
    stall_pct     <= 64;
    random_run(400);
    drain();

    // light idling on both sides
    send_idle_pct <= 11;
    stall_pct     <= 11;
    random_run(500);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
